/* sv/sti_pkg.sv */
package sti_pkg;

  localparam int KeyW          = 32;
  localparam int PayW          = 32;
  localparam int DataW         = KeyW + PayW;
  localparam int TableDepthDef = 32;

  typedef logic signed [KeyW-1:0] key_t;
  typedef logic [PayW-1:0]        pay_t;

  // Request kinds carried on the input tuser
  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_FIND   = 2'd1,
    REQ_DUMP   = 2'd2
  } req_e;

  // Result status carried on the output tuser
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  // Insert command broadcast to every cell
  typedef struct packed {
    logic en;
    key_t key;
    pay_t pay;
  } ins_t;

endpackage

/* sv/sti_cell.sv */
module sti_cell (
  input  logic          clk_i,
  input  sti_pkg::ins_t ins_i,
  input  logic          valid_i,
  input  logic          prev_le_i,
  input  sti_pkg::key_t prev_key_i,
  input  sti_pkg::pay_t prev_pay_i,
  output logic          le_o,
  output sti_pkg::key_t key_o,
  output sti_pkg::pay_t pay_o
);
  import sti_pkg::*;

  key_t key_q;
  pay_t pay_q;

  // Entry stays put when its key does not exceed the new key
  assign le_o = valid_i && !(ins_i.key < key_q);

  // Take the new record at the insert point, else take the lower neighbor
  always_ff @(posedge clk_i) begin
    if (ins_i.en && !le_o) begin
      if (prev_le_i) begin
        key_q <= ins_i.key;
        pay_q <= ins_i.pay;
      end else begin
        key_q <= prev_key_i;
        pay_q <= prev_pay_i;
      end
    end
  end

  assign key_o = key_q;
  assign pay_o = pay_q;

endmodule

/* sv/sorted_table_insert_search.sv */
// Sorted record table: a row of cells holds up to TABLE_DEPTH records
// (signed key, payload word) in ascending key order.
// Input channel s_axis: tuser selects the request (insert, find, dump),
// tdata carries key and payload. One request is taken at a time;
// tready is high while no request is in progress.
// Output channel m_axis: tdata carries key and payload of a result, tuser
// its status, tlast marks the final result of a request.
// Insert: every cell compares its key with the new key and larger entries
// move up one cell; a full table answers with full status.
// Find: one binary-search probe per cycle through the shared cell read
// mux; a miss answers with not-found status.
// Dump: one result per cycle after the accept cycle while m_axis is not
// stalled; entry_count results (one with empty status for an empty table).
// Results pass through an output register, so the next request is taken
// while a result still waits. A stalled receiver holds the output and
// pauses the request in progress. Reset empties the table and drops any
// pending result; cell contents are not cleared.
module sorted_table_insert_search #(
  parameter int TABLE_DEPTH = sti_pkg::TableDepthDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  input  logic [sti_pkg::DataW-1:0] s_axis_tdata,   // key [31:0], payload [63:32]
  input  logic [1:0]                s_axis_tuser,   // req_type [1:0]
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [sti_pkg::DataW-1:0] m_axis_tdata,   // out_key [31:0], out_payload [63:32]
  output logic [1:0]                m_axis_tuser,   // status [1:0]
  output logic                      m_axis_tlast    // last
);
  import sti_pkg::*;

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int LW = CW + 1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_INS  = 4'b0010,
    S_FIND = 4'b0100,
    S_DUMP = 4'b1000
  } state_e;

  state_e               state_q, state_d;
  key_t                 req_key_q;
  pay_t                 req_pay_q;
  logic [CW-1:0]        count_q, count_d;
  logic signed [LW-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [IW-1:0]        idx_q, idx_d;

  logic                 m_valid_q;
  key_t                 m_key_q;
  pay_t                 m_pay_q;
  status_e              m_st_q;
  logic                 m_last_q;

  logic                 out_free;
  logic                 emit;
  key_t                 emit_key;
  pay_t                 emit_pay;
  status_e              emit_st;
  logic                 emit_last;
  ins_t                 ins;

  logic [TABLE_DEPTH-1:0] le_w;
  logic [TABLE_DEPTH-1:0] vld_w;
  key_t                   keys_w [TABLE_DEPTH];
  pay_t                   pays_w [TABLE_DEPTH];

  logic [LW:0]          sum_w;
  logic [IW-1:0]        mid_w;
  logic [IW-1:0]        rd_idx;
  key_t                 rd_key;
  pay_t                 rd_pay;
  logic                 full_w;
  logic                 dump_last;

  assign s_axis_tready = (state_q == S_IDLE);
  assign out_free      = !m_valid_q || m_axis_tready;
  assign full_w        = (count_q == CW'(TABLE_DEPTH));

  // Row of cells
  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    assign vld_w[g] = (count_q > CW'(g));
    if (g == 0) begin : g_first
      sti_cell u_cell (
        .clk_i      (clk_i),
        .ins_i      (ins),
        .valid_i    (vld_w[g]),
        .prev_le_i  (1'b1),
        .prev_key_i (ins.key),
        .prev_pay_i (ins.pay),
        .le_o       (le_w[g]),
        .key_o      (keys_w[g]),
        .pay_o      (pays_w[g])
      );
    end else begin : g_rest
      sti_cell u_cell (
        .clk_i      (clk_i),
        .ins_i      (ins),
        .valid_i    (vld_w[g]),
        .prev_le_i  (le_w[g-1]),
        .prev_key_i (keys_w[g-1]),
        .prev_pay_i (pays_w[g-1]),
        .le_o       (le_w[g]),
        .key_o      (keys_w[g]),
        .pay_o      (pays_w[g])
      );
    end
  end

  // Binary-search midpoint and shared read port
  assign sum_w     = {lo_q[LW-1], lo_q} + {hi_q[LW-1], hi_q};
  assign mid_w     = sum_w[IW:1];
  assign rd_idx    = (state_q == S_FIND) ? mid_w : idx_q;
  assign rd_key    = keys_w[rd_idx];
  assign rd_pay    = pays_w[rd_idx];
  assign dump_last = ((CW'(idx_q) + CW'(1)) == count_q);

  // Request sequencing
  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    idx_d     = idx_q;
    emit      = 1'b0;
    emit_key  = '0;
    emit_pay  = '0;
    emit_st   = ST_OK;
    emit_last = 1'b1;
    ins.en    = 1'b0;
    ins.key   = req_key_q;
    ins.pay   = req_pay_q;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          case (s_axis_tuser)
            REQ_INSERT: state_d = S_INS;
            REQ_FIND: begin
              lo_d    = '0;
              hi_d    = $signed({1'b0, count_q}) - LW'(1);
              state_d = S_FIND;
            end
            REQ_DUMP: begin
              idx_d   = '0;
              state_d = S_DUMP;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_INS: begin
        if (out_free) begin
          emit    = 1'b1;
          state_d = S_IDLE;
          if (full_w) begin
            emit_st = ST_FULL;
          end else begin
            ins.en   = 1'b1;
            count_d  = count_q + CW'(1);
            emit_key = req_key_q;
            emit_pay = req_pay_q;
          end
        end
      end
      S_FIND: begin
        if (lo_q > hi_q) begin
          if (out_free) begin
            emit    = 1'b1;
            emit_st = ST_NOT_FOUND;
            state_d = S_IDLE;
          end
        end else if (rd_key == req_key_q) begin
          if (out_free) begin
            emit     = 1'b1;
            emit_key = rd_key;
            emit_pay = rd_pay;
            state_d  = S_IDLE;
          end
        end else if (rd_key < req_key_q) begin
          lo_d = $signed(LW'(mid_w)) + LW'(1);
        end else begin
          hi_d = $signed(LW'(mid_w)) - LW'(1);
        end
      end
      S_DUMP: begin
        if (out_free) begin
          emit = 1'b1;
          if (count_q == '0) begin
            emit_st = ST_EMPTY;
            state_d = S_IDLE;
          end else begin
            emit_key  = rd_key;
            emit_pay  = rd_pay;
            emit_last = dump_last;
            if (dump_last) begin
              state_d = S_IDLE;
            end else begin
              idx_d = idx_q + IW'(1);
            end
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      lo_q      <= '0;
      hi_q      <= '0;
      idx_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
      idx_q   <= idx_d;
      if (out_free) begin
        m_valid_q <= emit;
      end
    end
  end

  // Hold the request and the result payload
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      req_key_q <= key_t'(s_axis_tdata[KeyW-1:0]);
      req_pay_q <= s_axis_tdata[DataW-1:KeyW];
    end
    if (emit) begin
      m_key_q  <= emit_key;
      m_pay_q  <= emit_pay;
      m_st_q   <= emit_st;
      m_last_q <= emit_last;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {m_pay_q, m_key_q};
  assign m_axis_tuser  = m_st_q;
  assign m_axis_tlast  = m_last_q;

  // Checks
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INS && out_free && !full_w) |=> count_q == $past(count_q) + CW'(1))
    else $error("insert did not add one entry");

  a_full_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_INS && out_free && full_w) |=> $stable(count_q))
    else $error("refused insert changed the entry count");

  a_search_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIND) |-> (lo_q <= hi_q + LW'(1)))
    else $error("binary search bounds crossed by more than one");

  a_dump_index: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DUMP && count_q != '0) |-> (CW'(idx_q) < count_q))
    else $error("dump index past last entry");

endmodule
